[hdl/e2c_pkg.sv]
// Shared types and constants for the epoch-seconds to calendar converter.
// Used by e2c_ctrl, e2c_datapath and the top level; depends on nothing.
`default_nettype none
package e2c_pkg;

   // Width of every divisor, quotient and remainder in the shared divider
   localparam int unsigned DIV_W     = 17;
   // Dividend width and divider step-counter width (quotient step, remainder step)
   localparam int unsigned DIVD_W    = 32;
   localparam int unsigned STEP_W    = 1;

   localparam logic [DIV_W-1:0] SECS_PER_DAY      = 17'd86400;
   localparam logic [DIV_W-1:0] SECS_PER_HOUR     = 17'd3600;
   localparam logic [DIV_W-1:0] SECS_PER_MIN      = 17'd60;
   localparam logic [DIV_W-1:0] DAYS_PER_WEEK     = 17'd7;
   localparam logic [DIV_W-1:0] DAYS_PER_YEAR     = 17'd365;
   // 70 years of 365 days plus 17 leap days
   localparam logic [DIV_W-1:0] DAYS_1900_TO_1970 = 17'd25567;
   localparam logic [7:0]       YEARS_TO_2000     = 8'd100;
   localparam logic [3:0]       LAST_MONTH        = 4'd11;
   localparam logic [STEP_W-1:0] LAST_STEP        = 1'b1;

   // Reciprocals, rounded up; exact over each dividend's range
   localparam logic [25:0] RECIP_DAY  = 26'd50903317;  // 2^35 / 675, on secs >> 7
   localparam logic [15:0] RECIP_HOUR = 16'd37283;     // 2^27 / 3600
   localparam logic [12:0] RECIP_MIN  = 13'd4370;      // 2^18 / 60
   localparam logic [17:0] RECIP_WDAY = 18'd149797;    // 2^20 / 7
   localparam logic [15:0] RECIP_YEAR = 16'd45965;     // 2^24 / 365

   // Which quotient/remainder the shared divider is producing
   typedef enum logic [2:0] {
      DIV_DAY,
      DIV_HOUR,
      DIV_MIN,
      DIV_WDAY,
      DIV_YEAR
   } div_op_type;

   // Controller to datapath commands
   typedef struct packed {
      logic       load_in;
      logic       div_start;
      div_op_type div_op;
      logic       year_dec;
      logic       doy_latch;
      logic       mon_dec;
      logic       out_load;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic div_done;
      logic year_high;
      logic mon_high;
   } status_type;

   // Cumulative days before month index (0 = January)
   function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] idx);
      logic [8:0] d;
      case (idx)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd31;
         4'd2:    d = 9'd59;
         4'd3:    d = 9'd90;
         4'd4:    d = 9'd120;
         4'd5:    d = 9'd151;
         4'd6:    d = 9'd181;
         4'd7:    d = 9'd212;
         4'd8:    d = 9'd243;
         4'd9:    d = 9'd273;
         4'd10:   d = 9'd304;
         4'd11:   d = 9'd334;
         default: d = 9'd0;
      endcase
      if (leap && (idx >= 4'd2) && (idx <= 4'd11)) begin
         d = d + 9'd1;
      end
      return d;
   endfunction

endpackage
`default_nettype wire

[hdl/e2c_datapath.sv]
// Datapath: input capture, reciprocal-multiply divider by constants, year/month
// search and result register. Depends on e2c_pkg; driven by e2c_ctrl commands.
`default_nettype none
module e2c_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire e2c_pkg::cmd_type    cmd,
   input  wire logic [31:0]         in_secs,
   output e2c_pkg::status_type      status,
   output logic [39:0]              out_word
);

   // Captured input and intermediate results
   logic [31:0] secs_ff;
   logic [16:0] days_ff, remday_ff;
   logic [11:0] remhr_ff;
   logic [4:0]  hrs_ff;
   logic [5:0]  mins_ff, sec_ff;
   logic [2:0]  wday_ff;
   logic [7:0]  year_ff;
   logic [8:0]  doy_ff;
   logic [3:0]  mon_ff;
   logic [39:0] out_ff;

   // Divider state
   e2c_pkg::div_op_type            div_op_ff;
   logic                           div_busy_ff, div_busy_in;
   logic [e2c_pkg::STEP_W-1:0]     div_cnt_ff;
   logic [e2c_pkg::DIVD_W-1:0]     div_num_ff;
   logic [e2c_pkg::DIV_W-1:0]      div_quo_ff;

   logic [e2c_pkg::DIV_W-1:0]      divisor;
   logic [e2c_pkg::DIVD_W-1:0]     dividend;
   logic [e2c_pkg::DIV_W-1:0]      quo_nx;
   logic [e2c_pkg::DIVD_W-1:0]     prod_qd;
   logic [e2c_pkg::DIVD_W-1:0]     rem_full;
   logic [e2c_pkg::DIV_W-1:0]      rem_nx;
   logic                           div_last;

   logic [50:0] day_prod;
   logic [32:0] hour_prod;
   logic [24:0] min_prod;
   logic [34:0] wday_prod;
   logic [32:0] year_prod;

   logic [16:0] ystart;
   logic [7:0]  year_m1;
   logic        leap;
   logic [8:0]  mon_base;
   logic [8:0]  dom;
   logic [7:0]  year_out;

   // Divisor follows the running operation
   always_comb begin
      case (div_op_ff)
         e2c_pkg::DIV_DAY:  divisor = e2c_pkg::SECS_PER_DAY;
         e2c_pkg::DIV_HOUR: divisor = e2c_pkg::SECS_PER_HOUR;
         e2c_pkg::DIV_MIN:  divisor = e2c_pkg::SECS_PER_MIN;
         e2c_pkg::DIV_WDAY: divisor = e2c_pkg::DAYS_PER_WEEK;
         e2c_pkg::DIV_YEAR: divisor = e2c_pkg::DAYS_PER_YEAR;
         default:           divisor = e2c_pkg::DAYS_PER_YEAR;
      endcase
   end

   // Dividend picked at start
   always_comb begin
      case (cmd.div_op)
         e2c_pkg::DIV_DAY:  dividend = secs_ff;
         e2c_pkg::DIV_HOUR: dividend = {15'd0, remday_ff};
         e2c_pkg::DIV_MIN:  dividend = {20'd0, remhr_ff};
         e2c_pkg::DIV_WDAY: dividend = {15'd0, days_ff} + 32'd1;
         e2c_pkg::DIV_YEAR: dividend = {15'd0, days_ff};
         default:           dividend = {15'd0, days_ff};
      endcase
   end

   // Quotient step: multiply by the reciprocal and keep the top bits
   assign day_prod  = {26'd0, div_num_ff[31:7]} * {25'd0, e2c_pkg::RECIP_DAY};
   assign hour_prod = {16'd0, div_num_ff[16:0]} * {17'd0, e2c_pkg::RECIP_HOUR};
   assign min_prod  = {13'd0, div_num_ff[11:0]} * {12'd0, e2c_pkg::RECIP_MIN};
   assign wday_prod = {18'd0, div_num_ff[16:0]} * {17'd0, e2c_pkg::RECIP_WDAY};
   assign year_prod = {16'd0, div_num_ff[16:0]} * {17'd0, e2c_pkg::RECIP_YEAR};

   always_comb begin
      case (div_op_ff)
         e2c_pkg::DIV_DAY:  quo_nx = {1'b0, day_prod[50:35]};
         e2c_pkg::DIV_HOUR: quo_nx = {11'd0, hour_prod[32:27]};
         e2c_pkg::DIV_MIN:  quo_nx = {10'd0, min_prod[24:18]};
         e2c_pkg::DIV_WDAY: quo_nx = {2'd0, wday_prod[34:20]};
         e2c_pkg::DIV_YEAR: quo_nx = {8'd0, year_prod[32:24]};
         default:           quo_nx = {8'd0, year_prod[32:24]};
      endcase
   end

   // Remainder step on the registered quotient
   assign prod_qd  = {15'd0, div_quo_ff} * {15'd0, divisor};
   assign rem_full = div_num_ff - prod_qd;
   assign rem_nx   = rem_full[e2c_pkg::DIV_W-1:0];
   assign div_last = div_busy_ff && (div_cnt_ff == e2c_pkg::LAST_STEP);

   always_comb begin
      div_busy_in = div_busy_ff;
      if (cmd.div_start) begin
         div_busy_in = 1'b1;
      end else if (div_last) begin
         div_busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
      end else begin
         div_busy_ff <= div_busy_in;
      end
   end

   // Year start and day-of-year
   assign year_m1 = year_ff - 8'd1;
   assign ystart  = 17'({9'd0, year_ff} * e2c_pkg::DAYS_PER_YEAR) + {11'd0, year_m1[7:2]};
   assign leap    = (year_ff[1:0] == 2'b00) && (year_ff != 8'd0);
   assign mon_base = e2c_pkg::cum_days(leap, mon_ff);
   assign dom      = doy_ff - mon_base + 9'd1;
   assign year_out = year_ff - e2c_pkg::YEARS_TO_2000;

   assign status.div_done  = div_last;
   assign status.year_high = (year_ff > 8'd1) && (days_ff < ystart);
   assign status.mon_high  = (mon_ff != 4'd0) && (doy_ff < mon_base);

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         secs_ff <= in_secs;
      end
      if (cmd.div_start) begin
         div_op_ff  <= cmd.div_op;
         div_cnt_ff <= '0;
         div_num_ff <= dividend;
      end else if (div_busy_ff && !div_last) begin
         div_cnt_ff <= e2c_pkg::LAST_STEP;
         div_quo_ff <= quo_nx;
      end
      // Remainder step lands in its destination
      if (div_last) begin
         case (div_op_ff)
            e2c_pkg::DIV_DAY: begin
               days_ff   <= div_quo_ff + e2c_pkg::DAYS_1900_TO_1970;
               remday_ff <= rem_nx;
            end
            e2c_pkg::DIV_HOUR: begin
               hrs_ff   <= div_quo_ff[4:0];
               remhr_ff <= rem_nx[11:0];
            end
            e2c_pkg::DIV_MIN: begin
               mins_ff <= div_quo_ff[5:0];
               sec_ff  <= rem_nx[5:0];
            end
            e2c_pkg::DIV_WDAY: wday_ff <= rem_nx[2:0];
            e2c_pkg::DIV_YEAR: year_ff <= div_quo_ff[7:0];
            default: ;
         endcase
      end
      if (cmd.year_dec) begin
         year_ff <= year_m1;
      end
      if (cmd.doy_latch) begin
         doy_ff <= 9'(days_ff - ystart);
         mon_ff <= e2c_pkg::LAST_MONTH;
      end
      if (cmd.mon_dec) begin
         mon_ff <= mon_ff - 4'd1;
      end
      if (cmd.out_load) begin
         out_ff <= {3'd0, wday_ff, sec_ff, mins_ff, hrs_ff, dom[4:0],
                    mon_ff + 4'd1, year_out};
      end
   end

   assign out_word = out_ff;

endmodule
`default_nettype wire

[hdl/e2c_ctrl.sv]
// Controller: sequences the divider passes, the year and month searches and
// the result handshake. Depends on e2c_pkg; drives e2c_datapath.
`default_nettype none
module e2c_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   input  wire e2c_pkg::status_type  status,
   output e2c_pkg::cmd_type          cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DAY_GO,   S_DAY_RUN,
      S_HOUR_GO,  S_HOUR_RUN,
      S_MIN_GO,   S_MIN_RUN,
      S_WDAY_GO,  S_WDAY_RUN,
      S_YEAR_GO,  S_YEAR_RUN,
      S_YEAR_FIX, S_MON_FIX,
      S_DELIVER
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;

   assign in_ready  = (state_ff == S_IDLE);
   assign out_valid = valid_ff;

   // Next state, commands and result valid
   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff && !out_ready;
      cmd      = '0;
      cmd.div_op = e2c_pkg::DIV_DAY;
      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               cmd.load_in = 1'b1;
               state_in    = S_DAY_GO;
            end
         end
         S_DAY_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = e2c_pkg::DIV_DAY;
            state_in      = S_DAY_RUN;
         end
         S_DAY_RUN:  if (status.div_done) state_in = S_HOUR_GO;
         S_HOUR_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = e2c_pkg::DIV_HOUR;
            state_in      = S_HOUR_RUN;
         end
         S_HOUR_RUN: if (status.div_done) state_in = S_MIN_GO;
         S_MIN_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = e2c_pkg::DIV_MIN;
            state_in      = S_MIN_RUN;
         end
         S_MIN_RUN:  if (status.div_done) state_in = S_WDAY_GO;
         S_WDAY_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = e2c_pkg::DIV_WDAY;
            state_in      = S_WDAY_RUN;
         end
         S_WDAY_RUN: if (status.div_done) state_in = S_YEAR_GO;
         S_YEAR_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = e2c_pkg::DIV_YEAR;
            state_in      = S_YEAR_RUN;
         end
         S_YEAR_RUN: if (status.div_done) state_in = S_YEAR_FIX;
         // Step the year guess back until the day falls inside it
         S_YEAR_FIX: begin
            if (status.year_high) begin
               cmd.year_dec = 1'b1;
            end else begin
               cmd.doy_latch = 1'b1;
               state_in      = S_MON_FIX;
            end
         end
         // Walk the month down from December
         S_MON_FIX: begin
            if (status.mon_high) begin
               cmd.mon_dec = 1'b1;
            end else begin
               state_in = S_DELIVER;
            end
         end
         // Wait for the result register to be free
         S_DELIVER: begin
            if (!valid_ff || out_ready) begin
               cmd.out_load = 1'b1;
               valid_in     = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule
`default_nettype wire

[hdl/epoch_seconds_to_calendar.sv]
// Unsigned epoch seconds to broken-down calendar time, top level.
// Depends on e2c_pkg, e2c_ctrl and e2c_datapath.
//
// One word in, one word out. From the accepting edge to the edge that raises
// rsp_tvalid: five divisions by constants (day, hour, minute, weekday, year)
// run one after another, each as a start, a reciprocal-multiply and a
// remainder step; the year guess is then stepped back at most once, the
// month is searched down from December one per cycle, and the result
// register is loaded once it is free. One word is worked on at a time; a
// finished result sits in an output register, so the next word is taken
// while it waits, and a second result waits for that register to free.
// Years follow the plain four-year leap rule (2100 counts as leap).
`default_nettype none
module epoch_seconds_to_calendar (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] epoch_seconds
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata    // [7:0] year_from_2000, [11:8] month,
                                         // [16:12] day_of_month, [21:17] hours,
                                         // [27:22] minutes, [33:28] seconds_part,
                                         // [36:34] weekday, [39:37] zero
);

   e2c_pkg::cmd_type    cmd;
   e2c_pkg::status_type status;

   e2c_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   e2c_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .in_secs  (req_tdata),
      .status   (status),
      .out_word (rsp_tdata)
   );

   // Result fields stay in range
   a_month_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[11:8] >= 4'd1) && (rsp_tdata[11:8] <= 4'd12))
      else $error("month out of range");

   a_day_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[16:12] != 5'd0))
      else $error("day of month is zero");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[21:17] < 5'd24) && (rsp_tdata[36:34] < 3'd7))
      else $error("hours or weekday out of range");

   // A freshly accepted word cannot produce a result on the next cycle
   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !$rose(rsp_tvalid))
      else $error("result appeared too early");

endmodule
`default_nettype wire

[tb/tb_epoch_seconds_to_calendar.sv]
// Self-checking testbench for epoch_seconds_to_calendar: streams epoch-second words in,
// predicts each calendar word in the bench and compares the result words field by field.
// Depends only on the epoch_seconds_to_calendar RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb_epoch_seconds_to_calendar;

   localparam int unsigned CLK_PERIOD  = 20;
   localparam int unsigned N_RANDOM    = 1830;
   localparam int unsigned IDLE_LIMIT  = 12000;
   localparam int unsigned HOLD_CYCLES = 3000;
   localparam int unsigned HOLD_AT     = 1000;
   localparam int unsigned DRAIN_WAIT  = 400;
   localparam int unsigned CALM_FIRST  = 200;
   localparam int unsigned CALM_LAST   = 400;

   localparam int unsigned SEC_PER_DAY  = 86400;
   localparam int unsigned SEC_PER_HOUR = 3600;
   localparam int unsigned DAY_PER_YEAR = 365;
   localparam int unsigned DAYS_TO_1970 = 70 * 365 + 17;
   localparam int unsigned YEAR_2000    = 100;

   // Layout of rsp_tdata, highest field first
   typedef struct packed {
      logic [2:0]        pad;
      logic [2:0]        weekday;
      logic [5:0]        seconds_part;
      logic [5:0]        minutes;
      logic [4:0]        hours;
      logic [4:0]        day_of_month;
      logic [3:0]        month;
      logic signed [7:0] year_from_2000;
   } calendar_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   logic [31:0]  pending_secs[$];
   calendar_type expected_dates[$];

   int unsigned words_in    = 0;
   int unsigned words_out   = 0;
   int unsigned err_count   = 0;
   int unsigned burst_left  = 1;
   int unsigned gap_left    = 0;
   int unsigned stall_left  = 0;
   int unsigned idle_cycles = 0;
   logic        hold_rsp    = 1'b0;

   epoch_seconds_to_calendar u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Days before month m (0 = January); leap years gain a day from March on
   function automatic int unsigned days_before_month(bit leap, int unsigned m);
      int unsigned d;
      case (m)
         0:       d = 0;
         1:       d = 31;
         2:       d = 59;
         3:       d = 90;
         4:       d = 120;
         5:       d = 151;
         6:       d = 181;
         7:       d = 212;
         8:       d = 243;
         9:       d = 273;
         10:      d = 304;
         11:      d = 334;
         default: d = 0;
      endcase
      if (leap && m >= 2) d = d + 1;
      return d;
   endfunction

   // Broken-down time for one epoch word; day numbers count from 1900-01-01
   function automatic calendar_type calendar_of(logic [31:0] secs);
      calendar_type c;
      int unsigned  days, rem, yr, doy, mon;
      bit           leap;
      days = DAYS_TO_1970 + secs / SEC_PER_DAY;
      rem  = secs % SEC_PER_DAY;
      c = '0;
      c.hours        = 5'(rem / SEC_PER_HOUR);
      c.minutes      = 6'((rem % SEC_PER_HOUR) / 60);
      c.seconds_part = 6'(rem % 60);
      c.weekday      = 3'((days + 1) % 7);
      // year guess, stepped back until the day falls inside it
      yr = days / DAY_PER_YEAR;
      while (yr > 1 && days < DAY_PER_YEAR * yr + (yr - 1) / 4) yr--;
      doy  = days - (DAY_PER_YEAR * yr + (yr - 1) / 4);
      // plain four-year rule, 1900 itself excepted
      leap = (yr % 4 == 0) && (yr != 0);
      mon  = 11;
      while (mon > 0 && doy < days_before_month(leap, mon)) mon--;
      c.year_from_2000 = 8'(yr - YEAR_2000);
      c.month          = 4'(mon + 1);
      c.day_of_month   = 5'(doy - days_before_month(leap, mon) + 1);
      return c;
   endfunction

   task automatic check_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         err_count++;
      end
   endtask

   // Input driver: bursts of words with random gaps, none inside the calm window
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_dates.push_back(calendar_of(req_tdata));
            words_in++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_secs.size() != 0) begin
               req_tdata  <= pending_secs.pop_front();
               req_tvalid <= 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 8);
                  if ((words_in >= CALM_FIRST && words_in < CALM_LAST) || $urandom_range(0, 1))
                     gap_left = 0;
                  else
                     gap_left = $urandom_range(1, 200);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result side ready: random stalls, forced low during the long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else if (hold_rsp) begin
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!(words_out >= CALM_FIRST && words_out < CALM_LAST) &&
                   $urandom_range(0, 99) == 0) begin
         stall_left = $urandom_range(1, 220);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Long hold-off so the block fills and stalls its input
   initial begin
      wait (words_out >= HOLD_AT);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // Result monitor
   always @(posedge clock) begin
      calendar_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         words_out++;
         if (expected_dates.size() == 0) begin
            $error("result word %h with no expected date waiting", rsp_tdata);
            err_count++;
         end else begin
            want = expected_dates.pop_front();
            check_field("year_from_2000", int'(want.year_from_2000), int'(got.year_from_2000));
            check_field("month", want.month, got.month);
            check_field("day_of_month", want.day_of_month, got.day_of_month);
            check_field("hours", want.hours, got.hours);
            check_field("minutes", want.minutes, got.minutes);
            check_field("seconds_part", want.seconds_part, got.seconds_part);
            check_field("weekday", want.weekday, got.weekday);
            check_field("pad", want.pad, got.pad);
         end
      end
   end

   // Watchdog on cycles with no word accepted on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[epoch_seconds_to_calendar] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus and end of run
   initial begin
      int unsigned yr, jan1, doff, d, n_total;
      longint      t;
      // field extremes, year and leap edges, and the 2100 leap-day quirk
      pending_secs.push_back(32'd0);
      pending_secs.push_back(32'hFFFF_FFFF);
      pending_secs.push_back(32'h7FFF_FFFF);
      pending_secs.push_back(32'h8000_0000);
      pending_secs.push_back(32'hAAAA_AAAA);
      pending_secs.push_back(32'h5555_5555);
      pending_secs.push_back(32'd86399);
      pending_secs.push_back(32'd86400);
      pending_secs.push_back(32'd31535999);
      pending_secs.push_back(32'd31536000);
      pending_secs.push_back(32'd68083200);
      pending_secs.push_back(32'd68169599);
      pending_secs.push_back(32'd68169600);
      pending_secs.push_back(32'd94694399);
      pending_secs.push_back(32'd946684799);
      pending_secs.push_back(32'd946684800);
      pending_secs.push_back(32'd951782400);
      pending_secs.push_back(32'd951868800);
      pending_secs.push_back(32'd4102444799);
      pending_secs.push_back(32'd4102444800);
      pending_secs.push_back(32'd4107456000);
      pending_secs.push_back(32'd4107542399);
      pending_secs.push_back(32'd4107542400);

      for (int i = 0; i < N_RANDOM; i++) begin
         case ($urandom_range(0, 3))
            0: pending_secs.push_back($urandom);
            1: begin
               // around the start of a year, of March, or of the last day
               yr   = $urandom_range(1970, 2106);
               jan1 = 365 * (yr - 1970) + ((yr - 1) / 4 - 492);
               case ($urandom_range(0, 5))
                  0:       doff = 0;
                  1:       doff = 58;
                  2:       doff = 59;
                  3:       doff = 60;
                  4:       doff = 364;
                  default: doff = 365;
               endcase
               t = longint'(jan1 + doff) * SEC_PER_DAY + $urandom_range(0, 2) - 1;
               pending_secs.push_back(t[31:0]);
            end
            2: begin
               // time-of-day edges on a random day
               d = $urandom_range(0, 49710);
               case ($urandom_range(0, 5))
                  0:       t = 0;
                  1:       t = 59;
                  2:       t = 60;
                  3:       t = 3599;
                  4:       t = 3600;
                  default: t = 86399;
               endcase
               t = longint'(d) * SEC_PER_DAY + t;
               pending_secs.push_back(t[31:0]);
            end
            default: pending_secs.push_back($urandom_range(0, 32'hFFFF_FFFF));
         endcase
      end
      n_total = pending_secs.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // every word sent must come back; the watchdog ends a stuck run
      while (words_out < n_total) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (err_count == 0 && expected_dates.size() == 0)
         $display("[epoch_seconds_to_calendar] OK");
      else
         $display("[epoch_seconds_to_calendar] ERROR");
      $finish;
   end

endmodule
`default_nettype wire
